>>> src/pccq_pkg.sv
// ----------------------------------------------------------------------------
// pccq_pkg
// Shared types, codes and helpers for the poisoning capture chunk queue.
// ----------------------------------------------------------------------------
package pccq_pkg;

	localparam int QUEUE_SLOTS_DEF = 8;
	localparam logic [15:0] EXPECTED_BYTES_RST = 16'd1024;
	localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_TAKE     = 2'd1,
		CMD_EXT_DISC = 2'd2,
		CMD_METRIC   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_ACCEPTED     = 3'd0,
		STS_DROP_INVALID = 3'd1,
		STS_DROP_DISC    = 3'd2,
		STS_DROP_FULL    = 3'd3,
		STS_CHUNK        = 3'd4,
		STS_EMPTY        = 3'd5,
		STS_RESET_EPOCH  = 3'd6,
		STS_DONE         = 3'd7
	} status_t;

	localparam logic [3:0] MET_ACCEPTED  = 4'd0;
	localparam logic [3:0] MET_DELIVERED = 4'd1;
	localparam logic [3:0] MET_DISCARDED = 4'd2;
	localparam logic [3:0] MET_OVERFLOW  = 4'd3;
	localparam logic [3:0] MET_SHAPE     = 4'd4;
	localparam logic [3:0] MET_SEQDISC   = 4'd5;
	localparam logic [3:0] MET_EXTDISC   = 4'd6;
	localparam logic [3:0] MET_RESETS    = 4'd7;
	localparam logic [3:0] MET_PEAK      = 4'd8;
	localparam logic [3:0] MET_DEPTH     = 4'd9;

	localparam int CNT_ACCEPTED  = 0;
	localparam int CNT_DELIVERED = 1;
	localparam int CNT_PROD_DISC = 2;
	localparam int CNT_CONS_DISC = 3;
	localparam int CNT_OVERFLOW  = 4;
	localparam int CNT_SHAPE     = 5;
	localparam int CNT_SEQDISC   = 6;
	localparam int CNT_EXTDISC   = 7;
	localparam int CNT_RESETS    = 8;
	localparam int CNT_TOTAL     = 9;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] sequence_req;
		logic [63:0] captured_through_us;
		logic        playback_active;
		logic        payload_present;
		logic [15:0] byte_count;
		logic [3:0]  metric_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot_index;
		logic [31:0] sequence_out;
		logic [63:0] timestamp_out;
		logic        playback_active_out;
		logic [31:0] metric_value;
	} rsp_t;

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == SAT_MAX) ? v : v + 32'd1;
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? SAT_MAX : sum[31:0];
	endfunction

endpackage

>>> src/pccq_if.sv
// ----------------------------------------------------------------------------
// pccq_if
// Request, response and configuration channels of the chunk queue.
// ----------------------------------------------------------------------------
interface pccq_req_if;
	import pccq_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface pccq_rsp_if;
	import pccq_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface pccq_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/poisoning_capture_chunk_queue_unit.sv
// ----------------------------------------------------------------------------
// poisoning_capture_chunk_queue_unit
// Chunk descriptor FIFO that poisons itself on loss, with saturating metrics.
// ----------------------------------------------------------------------------
// Each request is captured in the idle state, which also reads the head
// slot from the descriptor memory (synchronous read); the exec state then
// checks, updates pointers and counters, writes the tail slot on a push and
// loads the response register. A held response stalls the exec state until
// it is taken, and no new request is accepted before the exec state ends.
// A new request is accepted while the previous response is still waiting.
// The config write port is always ready and is meant for idle periods only.
module poisoning_capture_chunk_queue_unit #(
	parameter int QUEUE_SLOTS = pccq_pkg::QUEUE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pccq_req_if.sink    req,
	pccq_rsp_if.source  rsp,
	pccq_cfg_if.sink    cfg
);
	import pccq_pkg::*;

	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int PW = SW + 1;
	localparam int DW = $clog2(QUEUE_SLOTS + 1);

	typedef struct packed {
		logic [31:0] seq;
		logic [63:0] ts;
		logic        act;
	} slot_t;

	slot_t       mem [QUEUE_SLOTS];
	slot_t       rd_data_q;
	slot_t       wr_data;
	logic        mem_we;
	logic [SW-1:0] wr_slot;
	logic [SW-1:0] rd_slot;

	state_t      state_q, state_d;
	req_t        req_q;
	rsp_t        rsp_q, rsp_d;
	logic        rsp_valid_q, rsp_valid_d;
	logic [15:0] exp_bytes_q;
	logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
	logic        poison_q, poison_d;
	logic        last_valid_q, last_valid_d;
	logic [31:0] last_seq_q, last_seq_d;
	logic [31:0] cnt_q [CNT_TOTAL];
	logic [31:0] cnt_d [CNT_TOTAL];
	logic [DW-1:0] peak_q, peak_d;
	logic [DW-1:0] depth;
	logic [PW:0]   diff;
	logic [31:0]   slot_wide;

	function automatic logic [SW-1:0] to_slot(logic [PW-1:0] p);
		return (p >= PW'(QUEUE_SLOTS)) ? SW'(p - PW'(QUEUE_SLOTS)) : SW'(p);
	endfunction

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(2 * QUEUE_SLOTS - 1)) ? '0 : p + PW'(1);
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign rd_slot = to_slot(rp_q);
	assign wr_slot = to_slot(wp_q);

	always_comb begin
		if (wp_q >= rp_q) begin
			diff = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			diff = {1'b0, wp_q} + (PW + 1)'(2 * QUEUE_SLOTS) - {1'b0, rp_q};
		end
		if (diff > (PW + 1)'(QUEUE_SLOTS)) begin
			depth = DW'(QUEUE_SLOTS);
		end else begin
			depth = DW'(diff);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_slot] <= wr_data;
		end
		rd_data_q <= mem[rd_slot];
	end

	always_comb begin
		state_d      = state_q;
		rsp_d        = rsp_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		wp_d         = wp_q;
		rp_d         = rp_q;
		poison_d     = poison_q;
		last_valid_d = last_valid_q;
		last_seq_d   = last_seq_q;
		peak_d       = peak_q;
		cnt_d        = cnt_q;
		mem_we       = 1'b0;
		wr_data      = '{seq: req_q.sequence_req, ts: req_q.captured_through_us,
			act: req_q.playback_active};
		slot_wide    = '0;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d     = ST_IDLE;
					rsp_valid_d = 1'b1;
					rsp_d       = '0;
					rsp_d.status = STS_DONE;
					case (req_q.command)
						CMD_PUSH: begin
							last_seq_d = req_q.sequence_req;
							if (last_valid_q && req_q.sequence_req != last_seq_q + 32'd1) begin
								cnt_d[CNT_SEQDISC]   = sat_inc(cnt_q[CNT_SEQDISC]);
								cnt_d[CNT_PROD_DISC] = sat_inc(cnt_q[CNT_PROD_DISC]);
								poison_d     = 1'b1;
								rsp_d.status = STS_DROP_DISC;
							end else begin
								last_valid_d = 1'b1;
								if (!req_q.payload_present || req_q.byte_count != exp_bytes_q) begin
									cnt_d[CNT_SHAPE]     = sat_inc(cnt_q[CNT_SHAPE]);
									cnt_d[CNT_PROD_DISC] = sat_inc(cnt_q[CNT_PROD_DISC]);
									poison_d     = 1'b1;
									rsp_d.status = STS_DROP_INVALID;
								end else if (depth >= DW'(QUEUE_SLOTS)) begin
									cnt_d[CNT_OVERFLOW]  = sat_inc(cnt_q[CNT_OVERFLOW]);
									cnt_d[CNT_PROD_DISC] = sat_inc(cnt_q[CNT_PROD_DISC]);
									poison_d     = 1'b1;
									rsp_d.status = STS_DROP_FULL;
								end else begin
									mem_we = 1'b1;
									wp_d   = ptr_inc(wp_q);
									cnt_d[CNT_ACCEPTED] = sat_inc(cnt_q[CNT_ACCEPTED]);
									if (depth + DW'(1) > peak_q) begin
										peak_d = depth + DW'(1);
									end
									slot_wide        = 32'(wr_slot);
									rsp_d.status     = STS_ACCEPTED;
									rsp_d.slot_index = slot_wide[2:0];
								end
							end
						end
						CMD_TAKE: begin
							if (poison_q) begin
								poison_d = 1'b0;
								cnt_d[CNT_CONS_DISC] = sat_add(cnt_q[CNT_CONS_DISC], 32'(depth));
								rp_d = wp_q;
								cnt_d[CNT_RESETS] = sat_inc(cnt_q[CNT_RESETS]);
								rsp_d.status = STS_RESET_EPOCH;
							end else if (depth == '0) begin
								rsp_d.status = STS_EMPTY;
							end else begin
								slot_wide                 = 32'(rd_slot);
								rsp_d.status              = STS_CHUNK;
								rsp_d.slot_index          = slot_wide[2:0];
								rsp_d.sequence_out        = rd_data_q.seq;
								rsp_d.timestamp_out       = rd_data_q.ts;
								rsp_d.playback_active_out = rd_data_q.act;
								rp_d = ptr_inc(rp_q);
								cnt_d[CNT_DELIVERED] = sat_inc(cnt_q[CNT_DELIVERED]);
							end
						end
						CMD_EXT_DISC: begin
							cnt_d[CNT_EXTDISC] = sat_inc(cnt_q[CNT_EXTDISC]);
							poison_d = 1'b1;
						end
						default: begin
							case (req_q.metric_index)
								MET_ACCEPTED:  rsp_d.metric_value = cnt_q[CNT_ACCEPTED];
								MET_DELIVERED: rsp_d.metric_value = cnt_q[CNT_DELIVERED];
								MET_DISCARDED: rsp_d.metric_value =
									sat_add(cnt_q[CNT_PROD_DISC], cnt_q[CNT_CONS_DISC]);
								MET_OVERFLOW:  rsp_d.metric_value = cnt_q[CNT_OVERFLOW];
								MET_SHAPE:     rsp_d.metric_value = cnt_q[CNT_SHAPE];
								MET_SEQDISC:   rsp_d.metric_value = cnt_q[CNT_SEQDISC];
								MET_EXTDISC:   rsp_d.metric_value = cnt_q[CNT_EXTDISC];
								MET_RESETS:    rsp_d.metric_value = cnt_q[CNT_RESETS];
								MET_PEAK:      rsp_d.metric_value = 32'(peak_q);
								MET_DEPTH:     rsp_d.metric_value = 32'(depth);
								default:       rsp_d.metric_value = '0;
							endcase
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rsp_valid_q  <= 1'b0;
			exp_bytes_q  <= EXPECTED_BYTES_RST;
			wp_q         <= '0;
			rp_q         <= '0;
			poison_q     <= 1'b0;
			last_valid_q <= 1'b0;
			last_seq_q   <= '0;
			peak_q       <= '0;
			for (int i = 0; i < CNT_TOTAL; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q      <= state_d;
			rsp_valid_q  <= rsp_valid_d;
			wp_q         <= wp_d;
			rp_q         <= rp_d;
			poison_q     <= poison_d;
			last_valid_q <= last_valid_d;
			last_seq_q   <= last_seq_d;
			peak_q       <= peak_d;
			cnt_q        <= cnt_d;
			if (cfg.valid) begin
				exp_bytes_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && state_q == ST_IDLE) begin
			req_q <= req.payload;
		end
		rsp_q <= rsp_d;
	end

endmodule

>>> bench/poisoning_capture_chunk_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisoning_capture_chunk_queue_unit_test
// Self-checking bench for the poisoning chunk queue. A clocked driver feeds
// requests from a backlog and predicts each reply at acceptance. A clocked
// monitor checks every reply field against the oldest prediction. The run
// covers directed corner requests, then random phases under four byte-count
// settings with random idling and long reply stalls.
// ----------------------------------------------------------------------------
module poisoning_capture_chunk_queue_unit_test;
	import pccq_pkg::*;

	localparam int QSLOTS = QUEUE_SLOTS_DEF;
	localparam int PTR_SPAN = 2 * QSLOTS;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam logic [3:0] MET_UNKNOWN = 4'd15;

	logic clk;
	logic arst_n;

	pccq_req_if req_ch();
	pccq_rsp_if rsp_ch();
	pccq_cfg_if cfg_ch();

	poisoning_capture_chunk_queue_unit #(
		.QUEUE_SLOTS(QSLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	req_t cmd_backlog[$];
	rsp_t predicted_replies[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_asks;
	int hold_taken;
	int hold_left;
	int idle_cycles;
	int mismatches;
	int requests_sent;
	int replies_checked;
	int status_seen[8];

	logic [31:0] gen_last;
	logic [15:0] gen_bytes;

	logic [31:0] slot_seq_m[QSLOTS];
	logic [63:0] slot_ts_m[QSLOTS];
	logic        slot_act_m[QSLOTS];
	int          wr_ptr_m;
	int          rd_ptr_m;
	logic        poisoned_m;
	logic        seq_seen_m;
	logic [31:0] last_seq_m;
	logic [31:0] tally[CNT_TOTAL];
	int          peak_m;
	logic [15:0] exp_bytes_m;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_model();
		for (int i = 0; i < QSLOTS; i++) begin
			slot_seq_m[i] = '0;
			slot_ts_m[i] = '0;
			slot_act_m[i] = 1'b0;
		end
		for (int i = 0; i < CNT_TOTAL; i++)
			tally[i] = '0;
		wr_ptr_m = 0;
		rd_ptr_m = 0;
		poisoned_m = 1'b0;
		seq_seen_m = 1'b0;
		last_seq_m = '0;
		peak_m = 0;
		exp_bytes_m = EXPECTED_BYTES_RST;
	endtask

	function automatic int fill_level();
		int d;
		d = (wr_ptr_m + PTR_SPAN - rd_ptr_m) % PTR_SPAN;
		return (d > QSLOTS) ? QSLOTS : d;
	endfunction

	task automatic tally_bump(int which);
		if (tally[which] != SAT_MAX)
			tally[which] = tally[which] + 32'd1;
	endtask

	function automatic logic [31:0] clip_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[32] ? SAT_MAX : total[31:0];
	endfunction

	task automatic queue_model_step(input req_t r, output rsp_t e);
		int d;
		int s;
		e = '0;
		e.status = STS_DONE;
		case (cmd_t'(r.command))
			CMD_PUSH: begin
				d = fill_level();
				if (seq_seen_m && r.sequence_req != last_seq_m + 32'd1) begin
					last_seq_m = r.sequence_req;
					tally_bump(CNT_SEQDISC);
					tally_bump(CNT_PROD_DISC);
					poisoned_m = 1'b1;
					e.status = STS_DROP_DISC;
				end else begin
					last_seq_m = r.sequence_req;
					seq_seen_m = 1'b1;
					if (!r.payload_present || r.byte_count != exp_bytes_m) begin
						tally_bump(CNT_SHAPE);
						tally_bump(CNT_PROD_DISC);
						poisoned_m = 1'b1;
						e.status = STS_DROP_INVALID;
					end else if (d >= QSLOTS) begin
						tally_bump(CNT_OVERFLOW);
						tally_bump(CNT_PROD_DISC);
						poisoned_m = 1'b1;
						e.status = STS_DROP_FULL;
					end else begin
						s = wr_ptr_m % QSLOTS;
						slot_seq_m[s] = r.sequence_req;
						slot_ts_m[s] = r.captured_through_us;
						slot_act_m[s] = r.playback_active;
						wr_ptr_m = (wr_ptr_m + 1) % PTR_SPAN;
						tally_bump(CNT_ACCEPTED);
						if (d + 1 > peak_m)
							peak_m = d + 1;
						e.status = STS_ACCEPTED;
						e.slot_index = s[2:0];
					end
				end
			end
			CMD_TAKE: begin
				if (poisoned_m) begin
					poisoned_m = 1'b0;
					tally[CNT_CONS_DISC] = clip_sum(tally[CNT_CONS_DISC], 32'(fill_level()));
					rd_ptr_m = wr_ptr_m;
					tally_bump(CNT_RESETS);
					e.status = STS_RESET_EPOCH;
				end else if (fill_level() == 0) begin
					e.status = STS_EMPTY;
				end else begin
					s = rd_ptr_m % QSLOTS;
					e.sequence_out = slot_seq_m[s];
					e.timestamp_out = slot_ts_m[s];
					e.playback_active_out = slot_act_m[s];
					e.slot_index = s[2:0];
					rd_ptr_m = (rd_ptr_m + 1) % PTR_SPAN;
					tally_bump(CNT_DELIVERED);
					e.status = STS_CHUNK;
				end
			end
			CMD_EXT_DISC: begin
				tally_bump(CNT_EXTDISC);
				poisoned_m = 1'b1;
			end
			default: begin
				case (r.metric_index)
					MET_ACCEPTED:  e.metric_value = tally[CNT_ACCEPTED];
					MET_DELIVERED: e.metric_value = tally[CNT_DELIVERED];
					MET_DISCARDED:
						e.metric_value = clip_sum(tally[CNT_PROD_DISC], tally[CNT_CONS_DISC]);
					MET_OVERFLOW:  e.metric_value = tally[CNT_OVERFLOW];
					MET_SHAPE:     e.metric_value = tally[CNT_SHAPE];
					MET_SEQDISC:   e.metric_value = tally[CNT_SEQDISC];
					MET_EXTDISC:   e.metric_value = tally[CNT_EXTDISC];
					MET_RESETS:    e.metric_value = tally[CNT_RESETS];
					MET_PEAK:      e.metric_value = 32'(peak_m);
					MET_DEPTH:     e.metric_value = 32'(fill_level());
					default:       e.metric_value = '0;
				endcase
			end
		endcase
	endtask

	task automatic flag_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got_v, want_v);
		mismatches++;
	endtask

	function automatic req_t make_other(cmd_t c, logic [3:0] m);
		req_t r;
		r.command = c;
		r.sequence_req = $urandom;
		r.captured_through_us = {$urandom, $urandom};
		r.playback_active = 1'($urandom_range(1));
		r.payload_present = 1'($urandom_range(1));
		r.byte_count = 16'($urandom);
		r.metric_index = m;
		return r;
	endfunction

	function automatic req_t make_push(logic [31:0] sq, logic present, logic [15:0] bytes);
		req_t r;
		r = make_other(CMD_PUSH, 4'($urandom));
		r.sequence_req = sq;
		r.payload_present = present;
		r.byte_count = bytes;
		gen_last = sq;
		return r;
	endfunction

	task automatic directed_items();
		req_t r;
		cmd_backlog.push_back(make_other(CMD_METRIC, MET_DEPTH));
		cmd_backlog.push_back(make_other(CMD_METRIC, MET_UNKNOWN));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		r = make_push(32'hFFFF_FFFF, 1'b1, gen_bytes);
		r.captured_through_us = '1;
		r.playback_active = 1'b1;
		cmd_backlog.push_back(r);
		r = make_push(32'h0, 1'b1, gen_bytes);
		r.captured_through_us = '0;
		r.playback_active = 1'b0;
		cmd_backlog.push_back(r);
		cmd_backlog.push_back(make_push(32'd1, 1'b0, gen_bytes));
		cmd_backlog.push_back(make_push(32'd5, 1'b1, gen_bytes));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		for (int i = 6; i <= 14; i++)
			cmd_backlog.push_back(make_push(32'(i), 1'b1, gen_bytes));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		cmd_backlog.push_back(make_push(32'd15, 1'b1, gen_bytes - 16'd1));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		cmd_backlog.push_back(make_push(32'd16, 1'b1, gen_bytes));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		cmd_backlog.push_back(make_other(CMD_EXT_DISC, MET_ACCEPTED));
		cmd_backlog.push_back(make_other(CMD_TAKE, MET_ACCEPTED));
		cmd_backlog.push_back(make_other(CMD_METRIC, MET_DISCARDED));
		cmd_backlog.push_back(make_other(CMD_METRIC, MET_PEAK));
	endtask

	task automatic random_items(int n);
		int k;
		logic [31:0] sq;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 44) begin
				cmd_backlog.push_back(make_push(gen_last + 32'd1, 1'b1, gen_bytes));
			end else if (k < 52) begin
				if ($urandom_range(1))
					cmd_backlog.push_back(make_push(gen_last + 32'd1, 1'b0, 16'($urandom)));
				else
					cmd_backlog.push_back(make_push(gen_last + 32'd1, 1'b1,
						gen_bytes ^ (16'd1 << $urandom_range(15))));
			end else if (k < 56) begin
				sq = $urandom_range(1) ? $urandom : {28'hFFF_FFFF, 4'($urandom)};
				cmd_backlog.push_back(make_push(sq, 1'($urandom), 16'($urandom)));
			end else if (k < 84) begin
				cmd_backlog.push_back(make_other(CMD_TAKE, 4'($urandom)));
			end else if (k < 89) begin
				cmd_backlog.push_back(make_other(CMD_EXT_DISC, 4'($urandom)));
			end else begin
				cmd_backlog.push_back(make_other(CMD_METRIC, 4'($urandom)));
			end
		end
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || req_ch.valid || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_expected_bytes(logic [15:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		exp_bytes_m = v;
		gen_bytes = v;
		repeat (2) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t guess;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				queue_model_step(req_ch.payload, guess);
				predicted_replies.push_back(guess);
				requests_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.payload <= cmd_backlog.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (predicted_replies.size() == 0) begin
					flag_mismatch("unexpected reply, status", 64'(got.status), 64'(STS_DONE));
				end else begin
					want = predicted_replies.pop_front();
					replies_checked++;
					status_seen[got.status]++;
					if (got.status !== want.status)
						flag_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.slot_index !== want.slot_index)
						flag_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
					if (got.sequence_out !== want.sequence_out)
						flag_mismatch("sequence_out", 64'(got.sequence_out),
							64'(want.sequence_out));
					if (got.timestamp_out !== want.timestamp_out)
						flag_mismatch("timestamp_out", got.timestamp_out, want.timestamp_out);
					if (got.playback_active_out !== want.playback_active_out)
						flag_mismatch("playback_active_out", 64'(got.playback_active_out),
							64'(want.playback_active_out));
					if (got.metric_value !== want.metric_value)
						flag_mismatch("metric_value", 64'(got.metric_value),
							64'(want.metric_value));
				end
			end
			if (hold_taken != hold_asks) begin
				hold_taken <= hold_asks;
				hold_left <= HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("poisoning_capture_chunk_queue_unit_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		send_idle_pct = 9;
		recv_idle_pct = 46;
		hold_asks = 0;
		hold_taken = 0;
		hold_left = 0;
		idle_cycles = 0;
		mismatches = 0;
		requests_sent = 0;
		replies_checked = 0;
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		gen_last = '0;
		gen_bytes = EXPECTED_BYTES_RST;
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed_items();
		random_items(150);
		hold_asks++;
		wait_drained();
		write_expected_bytes(16'h0000);
		random_items(150);
		wait_drained();

		send_idle_pct = 46;
		recv_idle_pct = 9;
		write_expected_bytes(16'hFFFF);
		random_items(150);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_expected_bytes(16'($urandom));
		random_items(150);
		hold_asks++;
		wait_drained();
		write_expected_bytes(EXPECTED_BYTES_RST);
		random_items(60);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d requests in five phases over four byte-count settings, %0d replies",
			requests_sent, replies_checked);
		$display("seen: %0d accepted, %0d chunks, %0d epoch resets, %0d full, %0d seq drops",
			status_seen[STS_ACCEPTED], status_seen[STS_CHUNK], status_seen[STS_RESET_EPOCH],
			status_seen[STS_DROP_FULL], status_seen[STS_DROP_DISC]);
		if (mismatches == 0 && predicted_replies.size() == 0)
			$display("poisoning_capture_chunk_queue_unit_test: clean");
		else
			$display("poisoning_capture_chunk_queue_unit_test: errors");
		$finish;
	end

endmodule
